// ===== rtl/fcstr_pkg.sv =====
package fcstr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TIMED = 3'b010,
    PH_RC    = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd1,
    KIND_SEL   = 2'd2,
    KIND_RC    = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [0:0] REG_TICKS_PER_UNIT = 1'b0;
  localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd5000;

  localparam int MAX_INPUT_CH = 4;

  localparam logic [9:0] FIXED_ABOVE = 10'd766;
  localparam logic [9:0] RC_BELOW    = 10'd256;

  localparam logic [9:0] SEL_BOUND [7] = '{
    10'd71, 10'd218, 10'd364, 10'd511, 10'd656, 10'd802, 10'd947
  };

  function automatic logic [6:0] sel_units(input logic [2:0] band);
    logic [6:0] u;
    case (band)
      3'd0:    u = 7'd2;
      3'd1:    u = 7'd4;
      3'd2:    u = 7'd6;
      3'd3:    u = 7'd12;
      3'd4:    u = 7'd24;
      3'd5:    u = 7'd36;
      3'd6:    u = 7'd60;
      default: u = 7'd120;
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/four_channel_sequential_timer_relay_top.sv =====
// latency: the result beat of an accepted event is valid in the cycle after acceptance
// throughput: one event per cycle; in_ready stays high while the result register is empty
//   or its beat is taken in the same cycle
// all event decoding, channel setup and counter updates sit between the state registers
// reset (synchronous, active high): sequencer idle, end level low, ticks_per_unit 5000
module four_channel_sequential_timer_relay_top #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic        bypass_level,
  input  logic [3:0]  enable_mask,
  input  logic [9:0]  type_code_0,
  input  logic [9:0]  type_code_1,
  input  logic [9:0]  type_code_2,
  input  logic [9:0]  type_code_3,
  input  logic [9:0]  value_code_0,
  input  logic [9:0]  value_code_1,
  input  logic [9:0]  value_code_2,
  input  logic [9:0]  value_code_3,
  input  logic        rc_ready_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  control_on,
  output logic        end_out,
  output logic        rc_start_pulse,
  output logic        busy_res,
  output logic [1:0]  active_index,
  output logic [6:0]  units_left
);
  import fcstr_pkg::*;

  localparam int USED_CH = (CHANNELS < MAX_INPUT_CH) ? CHANNELS : MAX_INPUT_CH;
  localparam int IDX_W   = (USED_CH > 1) ? $clog2(USED_CH) : 1;

  logic [15:0] ticks_per_unit;
  logic [15:0] limit;

  phase_t      phase, phase_next;
  logic [1:0]  cur, cur_next;
  logic [3:0]  en_ch, en_ch_next;
  kind_t       kind  [USED_CH];
  logic [6:0]  units [USED_CH];
  logic [6:0]  unit_cnt, unit_cnt_next;
  logic [15:0] tick_cnt, tick_cnt_next;
  logic        end_lvl, end_lvl_next;

  logic [9:0]  tc [MAX_INPUT_CH];
  logic [9:0]  vc [MAX_INPUT_CH];
  kind_t       kind_new  [USED_CH];
  logic [6:0]  units_new [USED_CH];

  logic        accept;
  logic        start;
  logic        do_setup;
  logic        pulse;
  logic [2:0]  from;
  logic [3:0]  src_en;
  logic        found;
  logic [IDX_W-1:0] sel_idx;
  kind_t       sel_kind;
  logic [6:0]  sel_u;
  logic [16:0] tick_inc;
  logic [6:0]  uc_dec;
  logic        busy_next;

  // config port
  assign pready = 1'b1;
  assign limit  = (ticks_per_unit == 16'd0) ? 16'd1 : ticks_per_unit;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TICKS_PER_UNIT) begin
      prdata = {16'd0, ticks_per_unit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TICKS_PER_UNIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TICKS_PER_UNIT) begin
      ticks_per_unit <= pwdata[15:0];
    end
  end

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // channel classification from the start beat
  assign tc[0] = type_code_0;
  assign tc[1] = type_code_1;
  assign tc[2] = type_code_2;
  assign tc[3] = type_code_3;
  assign vc[0] = value_code_0;
  assign vc[1] = value_code_1;
  assign vc[2] = value_code_2;
  assign vc[3] = value_code_3;

  always_comb begin
    logic [2:0] band;
    for (int c = 0; c < USED_CH; c++) begin
      band = 3'd0;
      for (int j = 0; j < 7; j++) begin
        band = band + 3'(vc[c] > SEL_BOUND[j]);
      end
      if (tc[c] > FIXED_ABOVE) begin
        kind_new[c]  = KIND_FIXED;
        units_new[c] = 7'd1;
      end else if (tc[c] < RC_BELOW) begin
        kind_new[c]  = KIND_RC;
        units_new[c] = 7'd0;
      end else begin
        kind_new[c]  = KIND_SEL;
        units_new[c] = sel_units(band);
      end
    end
  end

  // next enabled channel search
  assign start  = (mode == MODE_START) && (phase == PH_IDLE) && bypass_level;
  assign from   = start ? 3'd0 : ({1'b0, cur} + 3'd1);
  assign src_en = start ? enable_mask : en_ch;

  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    for (int i = USED_CH - 1; i >= 0; i--) begin
      if (src_en[i] && (i >= int'(from))) begin
        found   = 1'b1;
        sel_idx = IDX_W'(i);
      end
    end
  end

  assign sel_kind = start ? kind_new[sel_idx]  : kind[sel_idx];
  assign sel_u    = start ? units_new[sel_idx] : units[sel_idx];

  assign tick_inc = {1'b0, tick_cnt} + 17'd1;
  assign uc_dec   = (unit_cnt != 7'd0) ? (unit_cnt - 7'd1) : unit_cnt;

  always_comb begin
    phase_next    = phase;
    cur_next      = cur;
    en_ch_next    = en_ch;
    unit_cnt_next = unit_cnt;
    tick_cnt_next = tick_cnt;
    end_lvl_next  = end_lvl;
    do_setup      = 1'b0;
    pulse         = 1'b0;
    case (mode)
      MODE_STOP: begin
        phase_next   = PH_IDLE;
        end_lvl_next = 1'b1;
      end
      MODE_START: begin
        if (phase == PH_IDLE) begin
          if (bypass_level) begin
            end_lvl_next = 1'b0;
            en_ch_next   = enable_mask;
            cur_next     = 2'd0;
            do_setup     = 1'b1;
          end else begin
            end_lvl_next = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (phase == PH_TIMED) begin
          if (tick_inc >= {1'b0, limit}) begin
            tick_cnt_next = 16'd0;
            unit_cnt_next = uc_dec;
            if (uc_dec == 7'd0) begin
              do_setup = 1'b1;
            end
          end else begin
            tick_cnt_next = tick_inc[15:0];
          end
        end else if (phase == PH_RC) begin
          if (!rc_ready_level) begin
            do_setup = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (do_setup) begin
      if (found) begin
        cur_next = 2'(sel_idx);
        if (sel_kind == KIND_RC) begin
          phase_next    = PH_RC;
          unit_cnt_next = 7'd0;
          pulse         = 1'b1;
        end else begin
          phase_next    = PH_TIMED;
          unit_cnt_next = sel_u;
          tick_cnt_next = 16'd0;
        end
      end else begin
        phase_next   = PH_IDLE;
        end_lvl_next = 1'b1;
      end
    end
  end

  assign busy_next = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cur       <= 2'd0;
      en_ch     <= 4'd0;
      unit_cnt  <= 7'd0;
      tick_cnt  <= 16'd0;
      end_lvl   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        cur       <= cur_next;
        en_ch     <= en_ch_next;
        unit_cnt  <= unit_cnt_next;
        tick_cnt  <= tick_cnt_next;
        end_lvl   <= end_lvl_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start) begin
      for (int c = 0; c < USED_CH; c++) begin
        kind[c]  <= kind_new[c];
        units[c] <= units_new[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      control_on     <= busy_next ? (4'b0001 << cur_next) : 4'd0;
      end_out        <= end_lvl_next;
      rc_start_pulse <= pulse;
      busy_res       <= busy_next;
      active_index   <= busy_next ? cur_next : 2'd0;
      units_left     <= (phase_next == PH_TIMED) ? unit_cnt_next : 7'd0;
    end
  end

  a_stop_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_STOP) |=> (out_valid && end_out && !busy_res))
    else $error("stop beat did not end the sequence");

  a_busy_not_ended: assert property (@(posedge clk) disable iff (rst)
    (out_valid && busy_res) |-> !end_out)
    else $error("end level high while a sequence runs");

  a_pulse_rc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rc_start_pulse) |-> (busy_res && units_left == 7'd0))
    else $error("rc start pulse outside an rc channel setup");

  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (busy_res ? $onehot(control_on) : (control_on == 4'd0)))
    else $error("channel drive does not match busy state");

endmodule
